FILE: design/huffman_code_builder_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Huffman code builder
// Clocked implication checks, disabled while reset is applied.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication
`define HCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hcb assertion failed");

// Next-cycle implication
`define HCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hcb assertion failed");

`endif

FILE: design/hcb_pkg.sv
// ---------------------------------------------------------------------------
// hcb_pkg
// Shared constants, types and command codes of the Huffman code builder.
// ---------------------------------------------------------------------------
package hcb_pkg;

  localparam int MaxSymbols = 64;
  localparam int SymW       = 8;
  localparam int FreqW      = 16;
  localparam int WeightW    = 22;
  localparam int IdW        = 7;
  localparam int LeafAw     = 6;
  localparam int LenW       = 6;
  localparam int CodeW      = 63;
  localparam int CntW       = 7;
  localparam int ListDepth  = 128;
  localparam int ListAw     = 7;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [IdW-1:0]     id;
  } list_entry_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } walk_entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS_READ,
    CMD_INS_SHIFT,
    CMD_INS_PLACE,
    CMD_READ_A,
    CMD_READ_B,
    CMD_MERGE,
    CMD_READ_ROOT,
    CMD_SET_ROOT,
    CMD_READ_SYM,
    CMD_LOAD_OUT,
    CMD_POP_READ,
    CMD_POP_SET,
    CMD_READ_CHILD,
    CMD_PUSH,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } ctl_t;

  typedef struct packed {
    logic k_eq_head;
    logic shift_ge;
    logic len_ge2;
    logic leaf_full;
    logic cur_leaf;
    logic out_last;
  } stat_t;

endpackage

FILE: design/huffman_code_builder_unit.sv
// ---------------------------------------------------------------------------
// huffman_code_builder_unit
// Builds a Huffman code from a stream of (symbol, frequency) transactions.
// ---------------------------------------------------------------------------
// Each input transaction is sorted into a weight-ordered list held in RAM;
// a load reads and shifts each list entry of equal or greater weight that
// it passes, one at a time through the single read port of the list
// memory. The transaction with tlast set starts the build: each merge
// reads the two lightest entries and reinserts their sum, and the walk
// then descends through the inner nodes and emits one code per leaf,
// waiting for the downstream side. One run is handled at a time;
// s_axis_tready is low from a load until that load is sorted in, and from
// the last transaction until the final code (tlast on the output) is taken.
// No memory clear is needed after reset.
module huffman_code_builder_unit
  import hcb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // symbol[7:0], frequency[23:8]
  input  logic        s_axis_tlast,   // last_symbol
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // out_symbol[7:0], code_length[13:8],
                                      // code_bits[76:14], zero[79:77]
  output logic        m_axis_tlast,   // last_code
  output logic        m_axis_tuser    // overflow
);

  ctl_t             ctl;
  stat_t            stat;
  logic [SymW-1:0]  out_symbol;
  logic [LenW-1:0]  code_length;
  logic [CodeW-1:0] code_bits;

  hcb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid)
  );

  hcb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .symbol_i      (s_axis_tdata[7:0]),
    .frequency_i   (s_axis_tdata[23:8]),
    .stat_o        (stat),
    .out_symbol_o  (out_symbol),
    .code_length_o (code_length),
    .code_bits_o   (code_bits),
    .last_code_o   (m_axis_tlast),
    .overflow_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, code_bits, code_length, out_symbol};

`include "huffman_code_builder_unit_assert.svh"

  // input and output sides never open together
  `HCB_ASSERT_IMPL(a_one_side, s_axis_tready, !m_axis_tvalid)
  // a final transaction closes the input side for the build
  `HCB_ASSERT_NEXT(a_build_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // the final code returns the block to idle
  `HCB_ASSERT_NEXT(a_idle_after, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)

endmodule

FILE: design/hcb_ram.sv
// ---------------------------------------------------------------------------
// hcb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module hcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/hcb_ctrl.sv
// ---------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for loading, tree build, depth-first walk and result handoff.
// ---------------------------------------------------------------------------
module hcb_ctrl
  import hcb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  input  logic  s_last_i,
  input  logic  m_ready_i,
  input  stat_t stat_i,
  output ctl_t  ctl_o,
  output logic  s_ready_o,
  output logic  m_valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_WAIT,
    ST_BUILD,
    ST_POP_A,
    ST_POP_B,
    ST_ROOT_WAIT,
    ST_WALK,
    ST_SYM_WAIT,
    ST_EMIT,
    ST_CHILD_WAIT,
    ST_POP_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   building_q, building_d;
  logic   last_q, last_d;
  logic   m_valid_q, m_valid_d;
  cmd_e   op;
  state_e after_ins;

  // where to go once an insertion is placed
  assign after_ins = (building_q || last_q) ? ST_BUILD : ST_IDLE;

  // next state and command
  always_comb begin
    state_d    = state_q;
    building_d = building_q;
    last_d     = last_q;
    m_valid_d  = m_valid_q;
    op         = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          op         = CMD_LOAD;
          last_d     = s_last_i;
          building_d = 1'b0;
          if (!stat_i.leaf_full) begin
            state_d = ST_INS_CHK;
          end else if (s_last_i) begin
            state_d = ST_BUILD;
          end
        end
      end
      ST_INS_CHK: begin
        if (stat_i.k_eq_head) begin
          op      = CMD_INS_PLACE;
          state_d = after_ins;
        end else begin
          op      = CMD_INS_READ;
          state_d = ST_INS_WAIT;
        end
      end
      ST_INS_WAIT: begin
        if (stat_i.shift_ge) begin
          op      = CMD_INS_SHIFT;
          state_d = ST_INS_CHK;
        end else begin
          op      = CMD_INS_PLACE;
          state_d = after_ins;
        end
      end
      ST_BUILD: begin
        if (stat_i.len_ge2) begin
          op      = CMD_READ_A;
          state_d = ST_POP_A;
        end else begin
          op      = CMD_READ_ROOT;
          state_d = ST_ROOT_WAIT;
        end
      end
      ST_POP_A: begin
        op      = CMD_READ_B;
        state_d = ST_POP_B;
      end
      ST_POP_B: begin
        op         = CMD_MERGE;
        building_d = 1'b1;
        state_d    = ST_INS_CHK;
      end
      ST_ROOT_WAIT: begin
        op      = CMD_SET_ROOT;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (stat_i.cur_leaf) begin
          op      = CMD_READ_SYM;
          state_d = ST_SYM_WAIT;
        end else begin
          op      = CMD_READ_CHILD;
          state_d = ST_CHILD_WAIT;
        end
      end
      ST_SYM_WAIT: begin
        op        = CMD_LOAD_OUT;
        m_valid_d = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (m_ready_i) begin
          m_valid_d = 1'b0;
          if (stat_i.out_last) begin
            op      = CMD_CLEAR;
            last_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            op      = CMD_POP_READ;
            state_d = ST_POP_WAIT;
          end
        end
      end
      ST_POP_WAIT: begin
        op      = CMD_POP_SET;
        state_d = ST_WALK;
      end
      ST_CHILD_WAIT: begin
        op      = CMD_PUSH;
        state_d = ST_WALK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      building_q <= 1'b0;
      last_q     <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      building_q <= building_d;
      last_q     <= last_d;
      m_valid_q  <= m_valid_d;
    end
  end

  assign ctl_o.op  = op;
  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

FILE: design/hcb_dpath.sv
// ---------------------------------------------------------------------------
// hcb_dpath
// Sorted list, tree and walk stack memories with their pointers and the
// result register.
// ---------------------------------------------------------------------------
module hcb_dpath
  import hcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  input  logic [SymW-1:0]  symbol_i,
  input  logic [FreqW-1:0] frequency_i,
  output stat_t            stat_o,
  output logic [SymW-1:0]  out_symbol_o,
  output logic [LenW-1:0]  code_length_o,
  output logic [CodeW-1:0] code_bits_o,
  output logic             last_code_o,
  output logic             overflow_o
);

  localparam logic [IdW-1:0] FirstInner = IdW'(MaxSymbols);

  // control registers
  logic [CntW-1:0]   leaf_cnt_q;
  logic [ListAw-1:0] head_q;
  logic [CntW-1:0]   len_q;
  logic [ListAw-1:0] k_q;
  logic [IdW-1:0]    next_id_q;
  logic [CntW-1:0]   sp_q;
  logic              dropped_q;

  // payload registers
  list_entry_t       new_q;
  list_entry_t       a_q;
  walk_entry_t       cur_q;
  logic [SymW-1:0]   out_sym_q;
  logic [LenW-1:0]   out_len_q;
  logic [CodeW-1:0]  out_code_q;
  logic              out_last_q;
  logic              out_ovf_q;

  // memory ports
  logic              list_we, list_re;
  logic [ListAw-1:0] list_waddr, list_raddr;
  list_entry_t       list_wdata, list_rdata;
  logic              sym_we, sym_re;
  logic [SymW-1:0]   sym_rdata;
  logic              child_we, child_re;
  logic [2*IdW-1:0]  child_wdata, child_rdata;
  logic              stk_we, stk_re;
  walk_entry_t       stk_wdata, stk_rdata;
  logic [WeightW:0]  sum;
  list_entry_t       b_ent;

  assign b_ent = list_rdata;
  assign sum   = {1'b0, a_q.weight} + {1'b0, b_ent.weight};

  // memory port selection
  always_comb begin
    list_we    = 1'b0;
    list_re    = 1'b0;
    list_waddr = k_q;
    list_raddr = head_q;
    list_wdata = new_q;
    case (ctl_i.op)
      CMD_INS_READ: begin
        list_re    = 1'b1;
        list_raddr = k_q - ListAw'(1);
      end
      CMD_INS_SHIFT: begin
        list_we    = 1'b1;
        list_wdata = list_rdata;
      end
      CMD_INS_PLACE: list_we = 1'b1;
      CMD_READ_A, CMD_READ_ROOT: list_re = 1'b1;
      CMD_READ_B: begin
        list_re    = 1'b1;
        list_raddr = head_q + ListAw'(1);
      end
      default: ;
    endcase
  end

  assign sym_we      = (ctl_i.op == CMD_LOAD) && !stat_o.leaf_full;
  assign sym_re      = (ctl_i.op == CMD_READ_SYM);
  assign child_we    = (ctl_i.op == CMD_MERGE);
  assign child_re    = (ctl_i.op == CMD_READ_CHILD);
  assign child_wdata = {a_q.id, b_ent.id};
  assign stk_we      = (ctl_i.op == CMD_PUSH);
  assign stk_re      = (ctl_i.op == CMD_POP_READ);
  assign stk_wdata.id   = child_rdata[IdW-1:0];
  assign stk_wdata.code = {cur_q.code[CodeW-2:0], 1'b1};
  assign stk_wdata.len  = cur_q.len + LenW'(1);

  hcb_ram #(.Width($bits(list_entry_t)), .Depth(ListDepth)) u_list (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  hcb_ram #(.Width(SymW), .Depth(MaxSymbols)) u_sym (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (leaf_cnt_q[LeafAw-1:0]),
    .wdata_i (symbol_i),
    .re_i    (sym_re),
    .raddr_i (cur_q.id[LeafAw-1:0]),
    .rdata_o (sym_rdata)
  );

  hcb_ram #(.Width(2*IdW), .Depth(MaxSymbols)) u_child (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (next_id_q[LeafAw-1:0]),
    .wdata_i (child_wdata),
    .re_i    (child_re),
    .raddr_i (cur_q.id[LeafAw-1:0]),
    .rdata_o (child_rdata)
  );

  hcb_ram #(.Width($bits(walk_entry_t)), .Depth(MaxSymbols)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[LeafAw-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (LeafAw'(sp_q - CntW'(1))),
    .rdata_o (stk_rdata)
  );

  // advance control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_cnt_q <= '0;
      head_q     <= '0;
      len_q      <= '0;
      k_q        <= '0;
      next_id_q  <= FirstInner;
      sp_q       <= '0;
      dropped_q  <= 1'b0;
    end else begin
      case (ctl_i.op)
        CMD_LOAD: begin
          if (stat_o.leaf_full) begin
            dropped_q <= 1'b1;
          end else begin
            leaf_cnt_q <= leaf_cnt_q + CntW'(1);
            k_q        <= head_q + ListAw'(len_q);
          end
        end
        CMD_INS_SHIFT: k_q <= k_q - ListAw'(1);
        CMD_INS_PLACE: len_q <= len_q + CntW'(1);
        CMD_MERGE: begin
          next_id_q <= next_id_q + IdW'(1);
          head_q    <= head_q + ListAw'(2);
          len_q     <= len_q - CntW'(2);
          k_q       <= head_q + ListAw'(len_q);
        end
        CMD_SET_ROOT: sp_q <= '0;
        CMD_POP_READ: sp_q <= sp_q - CntW'(1);
        CMD_PUSH:     sp_q <= sp_q + CntW'(1);
        CMD_CLEAR: begin
          leaf_cnt_q <= '0;
          head_q     <= '0;
          len_q      <= '0;
          next_id_q  <= FirstInner;
          dropped_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      CMD_LOAD: begin
        new_q.weight <= WeightW'(frequency_i);
        new_q.id     <= IdW'(leaf_cnt_q);
      end
      CMD_READ_B: a_q <= list_rdata;
      CMD_MERGE: begin
        new_q.weight <= sum[WeightW-1:0];
        new_q.id     <= next_id_q;
      end
      CMD_SET_ROOT: begin
        cur_q.id   <= list_rdata.id;
        cur_q.code <= '0;
        cur_q.len  <= '0;
      end
      CMD_POP_SET: cur_q <= stk_rdata;
      CMD_PUSH: begin
        cur_q.id   <= child_rdata[2*IdW-1:IdW];
        cur_q.code <= {cur_q.code[CodeW-2:0], 1'b0};
        cur_q.len  <= cur_q.len + LenW'(1);
      end
      CMD_LOAD_OUT: begin
        out_sym_q  <= sym_rdata;
        out_len_q  <= cur_q.len;
        out_code_q <= cur_q.code;
        out_last_q <= (sp_q == '0);
        out_ovf_q  <= dropped_q;
      end
      default: ;
    endcase
  end

  assign stat_o.k_eq_head = (k_q == head_q);
  assign stat_o.shift_ge  = (list_rdata.weight >= new_q.weight);
  assign stat_o.len_ge2   = (len_q >= CntW'(2));
  assign stat_o.leaf_full = (leaf_cnt_q == CntW'(MaxSymbols));
  assign stat_o.cur_leaf  = (cur_q.id < FirstInner);
  assign stat_o.out_last  = out_last_q;

  assign out_symbol_o  = out_sym_q;
  assign code_length_o = out_len_q;
  assign code_bits_o   = out_code_q;
  assign last_code_o   = out_last_q;
  assign overflow_o    = out_ovf_q;

endmodule

FILE: test/huffman_code_builder_unit_tb.sv
// ---------------------------------------------------------------------------
// huffman_code_builder_unit_tb
// Self-checking bench for the Huffman code builder: runs of symbol
// transactions are streamed in, a behavioral code builder predicts every
// code, and each output transaction is compared field by field.
// ---------------------------------------------------------------------------
module huffman_code_builder_unit_tb;
  import hcb_pkg::*;

  localparam int NodeSlots = 2 * MaxSymbols - 1;
  localparam int WatchdogLimit = 40000;

  typedef struct {
    logic [SymW-1:0]  sym;
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
    logic             last;
    logic             ovf;
  } code_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // expected codes, oldest first
  code_t       code_q[$];
  int          err_cnt;
  int          send_idle;
  int          recv_idle;
  int          hold_cycles;
  int          quiet_cycles;

  // builder state mirrored from the block
  logic [WeightW-1:0] nd_weight [NodeSlots];
  logic [SymW-1:0]    nd_sym    [MaxSymbols];
  logic [IdW-1:0]     nd_left   [NodeSlots];
  logic [IdW-1:0]     nd_right  [NodeSlots];
  logic [IdW-1:0]     weight_order [NodeSlots];
  int                 order_len;
  int                 leaves_held;
  logic               leaf_dropped;

  huffman_code_builder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Place a node in front of all entries of equal or greater weight
  function automatic void order_insert(int id);
    int pos;
    pos = 0;
    while (pos < order_len && nd_weight[weight_order[pos]] < nd_weight[id]) pos++;
    for (int k = order_len; k > pos; k--) weight_order[k] = weight_order[k-1];
    weight_order[pos] = IdW'(id);
    order_len++;
  endfunction

  // Build the tree and queue one code per leaf in left-first walk order
  function automatic void build_codes();
    int         next_id;
    int         a;
    int         b;
    int         sp;
    int         id;
    int         n;
    int         stk_id  [MaxSymbols];
    logic [63:0] stk_code [MaxSymbols];
    int         stk_len [MaxSymbols];
    code_t      c;
    next_id = MaxSymbols;
    while (order_len >= 2 && next_id < NodeSlots) begin
      a = weight_order[0];
      b = weight_order[1];
      for (int k = 2; k < order_len; k++) weight_order[k-2] = weight_order[k];
      order_len -= 2;
      nd_weight[next_id] = nd_weight[a] + nd_weight[b];
      nd_left[next_id]   = IdW'(a);
      nd_right[next_id]  = IdW'(b);
      order_insert(next_id);
      next_id++;
    end
    stk_id[0]   = weight_order[0];
    stk_code[0] = '0;
    stk_len[0]  = 0;
    sp = 1;
    n  = 0;
    while (sp > 0 && n < MaxSymbols) begin
      sp--;
      id = stk_id[sp];
      if (id < MaxSymbols) begin
        c.sym  = nd_sym[id];
        c.len  = LenW'(stk_len[sp]);
        c.code = stk_code[sp][CodeW-1:0];
        c.last = 1'b0;
        c.ovf  = leaf_dropped;
        code_q.push_back(c);
        n++;
      end else if (sp + 2 <= MaxSymbols && stk_len[sp] < 63) begin
        stk_id[sp+1]   = nd_left[id];
        stk_code[sp+1] = stk_code[sp] << 1;
        stk_len[sp+1]  = stk_len[sp] + 1;
        stk_code[sp]   = (stk_code[sp] << 1) | 64'd1;
        stk_len[sp]    = stk_len[sp] + 1;
        stk_id[sp]     = nd_right[id];
        sp += 2;
      end
    end
    if (n > 0) code_q[$].last = 1'b1;
  endfunction

  // Update the mirrored state with one accepted transaction
  function automatic void predict_item(logic [7:0] sym, logic [15:0] freq, logic last);
    if (leaves_held < MaxSymbols) begin
      nd_weight[leaves_held] = WeightW'(freq);
      nd_sym[leaves_held]    = sym;
      order_insert(leaves_held);
      leaves_held++;
    end else begin
      leaf_dropped = 1'b1;
    end
    if (last) begin
      if (order_len > 0) build_codes();
      leaves_held  = 0;
      order_len    = 0;
      leaf_dropped = 1'b0;
    end
  endfunction

  // Offer one transaction, with a random gap ahead of it
  task automatic send_item(logic [7:0] sym, logic [15:0] freq, logic last);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {freq, sym};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(sym, freq, last);
  endtask

  // Send one run of n symbols; narrow weights give many ties
  task automatic send_run(int n, bit narrow);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom_range(255)),
                narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535)),
                i == n - 1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // lone symbol: empty code
    send_item(8'hFF, 16'd0, 1'b1);
    // extremes and equal weights, including merged ties
    send_item(8'h00, 16'hFFFF, 1'b0);
    send_item(8'hA5, 16'hFFFF, 1'b0);
    send_item(8'h5A, 16'hFFFF, 1'b1);
    for (int i = 0; i < 6; i++) send_item(8'(i), 16'd1, i == 5);
    // weights 1,1,2,4,8 ... give a deep, one-sided tree
    send_item(8'h10, 16'd1, 1'b0);
    for (int i = 0; i < 8; i++) send_item(8'(8'h11 + i), 16'(1 << i), i == 7);
    wait_drained();
  endtask

  // Full leaf store: extra transactions, the last one too, are dropped
  task automatic test_capacity();
    send_item(8'hC3, 16'd1, 1'b0);
    for (int i = 1; i < MaxSymbols; i++)
      send_item(8'($urandom_range(255)), 16'(i), 1'b0);
    send_item(8'h3C, 16'h8000, 1'b0);
    send_item(8'h7E, 16'h0001, 1'b1);
    // 64 leaves, one of weight 1 and the rest of weight 0: codes up to 63 bits
    send_item(8'h01, 16'd1, 1'b0);
    for (int i = 1; i < MaxSymbols; i++) send_item(8'(i), 16'd0, i == MaxSymbols - 1);
    wait_drained();
  endtask

  task automatic test_random(int n_items, int s_idle, int r_idle);
    int sent;
    int len;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = $urandom_range(MaxSymbols, 20);
        default: len = $urandom_range(12, 2);
      endcase
      if (len > n_items - sent) len = n_items - sent;
      send_run(len, $urandom_range(2) == 0);
      sent += len;
    end
    wait_drained();
  endtask

  // Stall the output while inputs keep coming
  task automatic test_backpressure();
    send_idle   = 0;
    hold_cycles = 400;
    send_run(10, 1'b0);
    send_run(5, 1'b1);
    wait_drained();
  endtask

  // Drive the output ready, with a counted long hold when asked
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each output transaction with the oldest expected code
  always @(posedge clk_i) begin
    code_t c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (code_q.size() == 0) begin
        $error("unexpected output transaction: symbol %0h", m_axis_tdata[7:0]);
        err_cnt++;
      end else begin
        c = code_q.pop_front();
        if (m_axis_tdata[7:0] !== c.sym) begin
          $error("out_symbol: expected %0h, got %0h", c.sym, m_axis_tdata[7:0]);
          err_cnt++;
        end
        if (m_axis_tdata[13:8] !== c.len) begin
          $error("code_length: expected %0d, got %0d", c.len, m_axis_tdata[13:8]);
          err_cnt++;
        end
        if (m_axis_tdata[76:14] !== c.code) begin
          $error("code_bits: expected %0h, got %0h", c.code, m_axis_tdata[76:14]);
          err_cnt++;
        end
        if (m_axis_tdata[79:77] !== 3'd0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata[79:77]);
          err_cnt++;
        end
        if (m_axis_tlast !== c.last) begin
          $error("last_code: expected %0b, got %0b", c.last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tuser !== c.ovf) begin
          $error("overflow: expected %0b, got %0b", c.ovf, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    err_cnt       = 0;
    send_idle     = 0;
    recv_idle     = 0;
    hold_cycles   = 0;
    quiet_cycles  = 0;
    leaves_held   = 0;
    order_len     = 0;
    leaf_dropped  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 10;
    recv_idle = 72;
    test_directed();
    test_capacity();
    test_random(25, 10, 72);
    test_random(25, 72, 10);
    test_random(20, 0, 0);
    test_backpressure();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && code_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/hcb_pkg.sv
design/hcb_ram.sv
design/hcb_ctrl.sv
design/hcb_dpath.sv
design/huffman_code_builder_unit.sv
test/huffman_code_builder_unit_tb.sv
